[rtl/core/sqrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrg_pkg
// Shared types, constants and the envelope table builder for the squelch
// ramp gate.
// ----------------------------------------------------------------------------
package sqrg_pkg;

  localparam int TABLE_BITS_DFLT = 8;
  localparam int MAX_RAMP        = 1024;

  localparam int SMP_W   = 16;
  localparam int ENV_W   = 17;
  localparam int PH_W    = 17;
  localparam int RC_W    = 11;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [ENV_W-1:0] UNITY     = ENV_W'(32768);
  localparam logic [PH_W-1:0]  PHASE_END = PH_W'(65536);
  localparam logic [RC_W-1:0]  RC_MAX    = '1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_RAMP_LENGTH = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [1:0] REG_GATE_ENABLE = 2'd2;

  typedef enum logic [3:0] {
    MODE_SILENT = 4'b0001,
    MODE_RISE   = 4'b0010,
    MODE_OPEN   = 4'b0100,
    MODE_FALL   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    mute_request;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
  } out_t;

  typedef struct packed {
    logic [RC_W-1:0] ramp_length;
    logic [PH_W-1:0] phase_step;
    logic            gate_enable;
    logic            ramp_wr;
    logic [RC_W-1:0] ramp_wdata;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    emit;
    logic signed [SMP_W-1:0] sample;
    logic [ENV_W-1:0]        gain;
  } s1_t;

  // Clamp the programmed ramp to the supported maximum.
  function automatic logic [RC_W-1:0] eff_ramp(input logic [RC_W-1:0] r);
    logic [RC_W-1:0] res;
    begin
      if (32'(r) > 32'(MAX_RAMP)) res = RC_W'(MAX_RAMP);
      else res = r;
      return res;
    end
  endfunction

  // Raised-cosine entry: sin^2(pi/2 * i/2^tbits) via a Q30 odd polynomial.
  function automatic logic [ENV_W-1:0] tab_entry(input int unsigned i,
                                                  input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] q30;
    begin
      q30 = 64'd1 << 30;
      if (i == 0) return '0;
      if (64'(i) >= (64'd1 << tbits)) return UNITY;
      x = (64'd1686629713 * 64'(i)) >> tbits;
      y = (x * x) >> 30;
      a = q30 - y / 64'd72;
      a = q30 - ((y * a) >> 30) / 64'd42;
      a = q30 - ((y * a) >> 30) / 64'd20;
      a = q30 - ((y * a) >> 30) / 64'd6;
      s = (x * a) >> 30;
      e = (s * s + (64'd1 << 44)) >> 45;
      if (e > 64'(UNITY)) e = 64'(UNITY);
      return ENV_W'(e);
    end
  endfunction

endpackage

[rtl/core/sqrg_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrg_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface sqrg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sqrg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrg_cfg
// APB register file: ramp length, phase step and gate enable.
// ----------------------------------------------------------------------------
module sqrg_cfg
  import sqrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [RC_W-1:0] ramp_length;
  logic [PH_W-1:0] phase_step;
  logic            gate_enable;
  logic            wr;
  logic [1:0]      idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_length <= '0;
      phase_step  <= '0;
      gate_enable <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_RAMP_LENGTH: ramp_length <= pwdata[RC_W-1:0];
        REG_PHASE_STEP:  phase_step  <= pwdata[PH_W-1:0];
        REG_GATE_ENABLE: gate_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAMP_LENGTH: prdata = DATA_W'(ramp_length);
      REG_PHASE_STEP:  prdata = DATA_W'(phase_step);
      REG_GATE_ENABLE: prdata = DATA_W'(gate_enable);
      default:         prdata = '0;
    endcase
  end

  assign cfg.ramp_length = ramp_length;
  assign cfg.phase_step  = phase_step;
  assign cfg.gate_enable = gate_enable;
  assign cfg.ramp_wr     = wr && (idx == REG_RAMP_LENGTH);
  assign cfg.ramp_wdata  = pwdata[RC_W-1:0];

endmodule

[rtl/core/sqrg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrg_ctrl
// Mute state machine, ramp phase accumulator and envelope table lookup;
// registers the sample and its gain for the output stage.
// ----------------------------------------------------------------------------
module sqrg_ctrl
  import sqrg_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DFLT
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         advance,
  sqrg_stream_if.sink  in_item,
  output s1_t          s1
);

  localparam int TAB_N = 1 << TABLE_BITS;
  localparam int IDX_W = TABLE_BITS + 1;
  localparam int SH    = 16 - TABLE_BITS;
  localparam int RND   = (1 << SH) >> 1;

  logic [ENV_W-1:0] cos_tab [TAB_N+1];

  for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
    assign cos_tab[g] = tab_entry(g, TABLE_BITS);
  end

  mode_t            mode, mode_next;
  logic [RC_W-1:0]  ramp_count, ramp_count_next;
  logic [PH_W-1:0]  phase, phase_next;
  logic [ENV_W-1:0] envelope, envelope_next;
  s1_t              s1_next;

  logic             accept;
  logic             mute;
  logic [RC_W-1:0]  ramp;
  logic [PH_W:0]    ph_sum;
  logic [PH_W-1:0]  ph_up;
  logic [PH_W-1:0]  ph_dn;
  logic [RC_W-1:0]  cnt_up;
  logic [PH_W-1:0]  lk_phase;
  logic [PH_W:0]    lk_round;
  logic [PH_W:0]    idx_full;
  logic [IDX_W-1:0] idx;
  logic [ENV_W-1:0] tab_val;

  assign in_item.ready = !s1.valid || advance;
  assign accept        = in_item.valid && in_item.ready;
  assign mute          = in_item.data.mute_request;

  always_comb begin
    ramp   = eff_ramp(cfg.ramp_length);
    ph_sum = {1'b0, phase} + {1'b0, cfg.phase_step};
    ph_up  = (ph_sum > {1'b0, PHASE_END}) ? PHASE_END : ph_sum[PH_W-1:0];
    ph_dn  = (phase > cfg.phase_step) ? (phase - cfg.phase_step) : '0;
    cnt_up = (ramp_count != RC_MAX) ? (ramp_count + 1'b1) : ramp_count;

    // round the phase to the nearest table index
    if (cfg.ramp_wr)              lk_phase = phase;
    else if (mode == MODE_RISE)   lk_phase = ph_up;
    else                          lk_phase = ph_dn;
    lk_round = {1'b0, lk_phase} + (PH_W+1)'(RND);
    idx_full = lk_round >> SH;
    idx      = (idx_full > (PH_W+1)'(TAB_N)) ? IDX_W'(TAB_N) : idx_full[IDX_W-1:0];
    tab_val  = cos_tab[idx];
  end

  always_comb begin
    mode_next       = mode;
    ramp_count_next = ramp_count;
    phase_next      = phase;
    envelope_next   = envelope;
    if (accept) begin
      case (mode)
        MODE_SILENT: begin
          if (!mute) begin
            if (ramp != '0) begin
              mode_next = MODE_RISE;
            end else begin
              mode_next     = MODE_OPEN;
              envelope_next = UNITY;
            end
          end
        end
        MODE_OPEN: begin
          if (mute) begin
            if (ramp != '0) begin
              mode_next = MODE_FALL;
            end else begin
              mode_next       = MODE_SILENT;
              ramp_count_next = '0;
              phase_next      = '0;
            end
          end
        end
        MODE_RISE: begin
          ramp_count_next = cnt_up;
          phase_next      = ph_up;
          envelope_next   = tab_val;
          if (cnt_up >= ramp) begin
            mode_next     = MODE_OPEN;
            envelope_next = UNITY;
            phase_next    = PHASE_END;
          end
        end
        MODE_FALL: begin
          if (ramp_count != '0 && ramp != '0) begin
            ramp_count_next = ramp_count - 1'b1;
            phase_next      = ph_dn;
            envelope_next   = tab_val;
          end else begin
            ramp_count_next = '0;
          end
          if (ramp_count_next == '0) begin
            mode_next     = MODE_SILENT;
            phase_next    = '0;
            envelope_next = '0;
          end
        end
        default: begin
          mode_next = MODE_SILENT;
        end
      endcase
    end else if (cfg.ramp_wr) begin
      // reload the envelope for the new ramp length
      if (eff_ramp(cfg.ramp_wdata) == '0 || mode == MODE_OPEN) envelope_next = UNITY;
      else envelope_next = tab_val;
    end
  end

  always_comb begin
    s1_next = s1;
    if (accept) begin
      s1_next.valid  = 1'b1;
      s1_next.emit   = (mode_next != MODE_SILENT) || !cfg.gate_enable;
      s1_next.sample = in_item.data.sample_in;
      s1_next.gain   = (mode_next == MODE_SILENT) ? '0 : envelope_next;
    end else if (advance) begin
      s1_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SILENT;
      ramp_count <= '0;
      phase      <= '0;
      envelope   <= UNITY;
      s1.valid   <= 1'b0;
      s1.emit    <= 1'b0;
    end else begin
      mode       <= mode_next;
      ramp_count <= ramp_count_next;
      phase      <= phase_next;
      envelope   <= envelope_next;
      s1.valid   <= s1_next.valid;
      s1.emit    <= s1_next.emit;
    end
    s1.sample <= s1_next.sample;
    s1.gain   <= s1_next.gain;
  end

endmodule

[rtl/core/sqrg_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrg_mult
// Output stage: sample times unsigned Q2.15 gain, floored, into the result register.
// ----------------------------------------------------------------------------
module sqrg_mult
  import sqrg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  s1_t           s1,
  output logic          free,
  sqrg_stream_if.source out_item
);

  logic signed [SMP_W-1:0]       smp;
  logic signed [ENV_W:0]         gain_s;
  logic signed [SMP_W+ENV_W:0]   prod;

  assign smp    = s1.sample;
  assign gain_s = $signed({1'b0, s1.gain});
  assign prod   = smp * gain_s;
  assign free   = !out_item.valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (free) begin
      out_item.valid <= s1.valid && s1.emit;
    end
  end

  // arithmetic shift right by 15 keeps the floor rounding
  always_ff @(posedge clk) begin
    if (free) begin
      out_item.data.sample_out <= prod[SMP_W+14:15];
    end
  end

endmodule

[rtl/core/squelch_ramp_gate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squelch_ramp_gate
// Audio squelch with a raised-cosine attack/decay envelope.
// ----------------------------------------------------------------------------
// Takes one Q1.15 sample per clock together with a mute request and returns
// the sample scaled by the current envelope. The block is a two-stage
// pipeline: the first register stage updates the mute state, ramp count,
// phase and envelope (one phase add or subtract, one rounding add and one
// table read), the second multiplies the sample by the gain into the result
// register. A new sample is taken every cycle as long as results are
// drained; a result passes the stage-one register and then the output
// register, and a stalled result holds while one more sample waits behind
// it. While muted the block returns zero, or no result at all with
// gate_enable set. Program phase_step as 65536 / ramp_length; writing
// ramp_length reloads the envelope. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module squelch_ramp_gate
  import sqrg_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  sqrg_stream_if.sink       in_item,
  sqrg_stream_if.source     out_item
);

  cfg_t cfg;
  s1_t  s1;
  logic out_free;

  sqrg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sqrg_ctrl #(
    .TABLE_BITS (TABLE_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (out_free),
    .in_item (in_item),
    .s1      (s1)
  );

  sqrg_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .free     (out_free),
    .out_item (out_item)
  );

  // input stalls only when both stages are full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_item.ready |-> (s1.valid && out_item.valid && !out_item.ready))
    else $error("input stalled with room in the pipeline");

  // with gating off every transfer in yields a result
  a_no_drop_ungated: assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && in_item.ready && !cfg.gate_enable) |=> (s1.valid && s1.emit))
    else $error("sample lost with gate disabled");

  // unity gain passes the sample through unchanged
  a_unity_passthrough: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.emit && s1.gain == UNITY && out_free)
      |=> (out_item.data.sample_out == $past(s1.sample)))
    else $error("unity gain altered the sample");

endmodule

[tb/squelch_ramp_gate_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squelch_ramp_gate_test
// Self-checking testbench for the raised-cosine squelch gate. A scoreboard
// class tracks mute state, ramp position and envelope for every accepted
// sample and checks each output transfer in order. Directed vectors cover
// instant switching, broken ramps and envelope reloads; random mute runs
// then sweep several register settings under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module squelch_ramp_gate_test;
  import sqrg_pkg::*;

  localparam int          CURVE_BITS  = TABLE_BITS_DFLT;
  localparam int          CURVE_N     = 1 << CURVE_BITS;
  localparam int          CYCLE_LIMIT = 300000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  class envelope_gain_model;
    bit [RC_W-1:0]  ramp_len;
    bit [PH_W-1:0]  step;
    bit             gate_on;
    mode_t          md;
    bit [RC_W-1:0]  count;
    bit [PH_W-1:0]  ph;
    bit [ENV_W-1:0] env;
    bit [ENV_W-1:0] curve [CURVE_N+1];
    out_t           expected_out [$];
    int             errors;
    int             samples_taken;
    int             outputs_checked;

    function new();
      longint unsigned x, y, a, s, e, q30;
      int i;
      q30 = 64'd1 << 30;
      for (i = 0; i <= CURVE_N; i++) begin
        if (i == 0) begin
          curve[i] = '0;
        end else if (i >= CURVE_N) begin
          curve[i] = UNITY;
        end else begin
          x = (64'd1686629713 * longint'(i)) >> CURVE_BITS;
          y = (x * x) >> 30;
          a = q30 - y / 72;
          a = q30 - ((y * a) >> 30) / 42;
          a = q30 - ((y * a) >> 30) / 20;
          a = q30 - ((y * a) >> 30) / 6;
          s = (x * a) >> 30;
          e = (s * s + (64'd1 << 44)) >> 45;
          if (e > 32768) e = 32768;
          curve[i] = ENV_W'(e);
        end
      end
      ramp_len = '0;
      step = '0;
      gate_on = 1'b0;
      md = MODE_SILENT;
      count = '0;
      ph = '0;
      env = UNITY;
    endfunction

    function int unsigned active_ramp();
      return (ramp_len > MAX_RAMP) ? MAX_RAMP : ramp_len;
    endfunction

    // Round the phase to the nearest curve point.
    function bit [ENV_W-1:0] lookup(int unsigned p);
      int unsigned sh, idx;
      sh = 16 - CURVE_BITS;
      idx = (p + ((1 << sh) >> 1)) >> sh;
      if (idx > CURVE_N) idx = CURVE_N;
      return curve[idx];
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_RAMP_LENGTH: begin
          ramp_len = val[RC_W-1:0];
          if (active_ramp() == 0 || md == MODE_OPEN) env = UNITY;
          else env = lookup(ph);
        end
        REG_PHASE_STEP:  step = val[PH_W-1:0];
        REG_GATE_ENABLE: gate_on = val[0];
        default: ;
      endcase
    endfunction

    function void take_sample(in_t it);
      int unsigned r, nph;
      longint prod;
      out_t res;
      r = active_ramp();
      samples_taken++;
      case (md)
        MODE_SILENT: begin
          if (!it.mute_request) begin
            if (r != 0) begin
              md = MODE_RISE;
            end else begin
              md = MODE_OPEN;
              env = UNITY;
            end
          end
        end
        MODE_OPEN: begin
          if (it.mute_request) begin
            if (r != 0) begin
              md = MODE_FALL;
            end else begin
              md = MODE_SILENT;
              count = '0;
              ph = '0;
            end
          end
        end
        MODE_RISE: begin
          if (count != '1) count++;
          nph = ph + step;
          if (nph > PHASE_END) nph = PHASE_END;
          ph = PH_W'(nph);
          env = lookup(ph);
          if (count >= r) begin
            md = MODE_OPEN;
            env = UNITY;
            ph = PHASE_END;
          end
        end
        default: begin
          if (count != 0 && r != 0) begin
            count--;
            ph = (ph > step) ? ph - step : '0;
            env = lookup(ph);
          end else begin
            count = '0;
          end
          if (count == 0) begin
            md = MODE_SILENT;
            ph = '0;
            env = '0;
          end
        end
      endcase

      if (md != MODE_SILENT) begin
        prod = longint'(it.sample_in) * longint'(env);
        res.sample_out = SMP_W'(prod >>> 15);
        expected_out.push_back(res);
      end else if (!gate_on) begin
        res.sample_out = '0;
        expected_out.push_back(res);
      end
    endfunction

    function void check_output(out_t got);
      out_t want;
      if (expected_out.size() == 0) begin
        $error("sample_out: expected none, actual %0d", got.sample_out);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      outputs_checked++;
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sqrg_stream_if #(.payload_t(in_t))  in_ch ();
  sqrg_stream_if #(.payload_t(out_t)) out_ch ();

  squelch_ramp_gate dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  envelope_gain_model board;
  int          burst_left;
  bit          quiet;
  bit [31:0]   stall_mask;
  int unsigned stall_tick;
  int          cycle_count;
  int          regs_written;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("squelch_ramp_gate_test NOT OK");
      $finish;
    end
  end

  // Receiver: stall on a random mask that is reloaded with fresh random bits.
  always @(negedge clk) begin
    if (stall_tick % 64 == 0) begin
      stall_mask = $urandom;
      if ($urandom_range(0, 1)) stall_mask = stall_mask & $urandom;
    end
    out_ch.ready <= quiet || !stall_mask[stall_tick % 32];
    stall_tick++;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) board.check_output(out_ch.data);
  end

  function automatic in_t make_item(logic signed [SMP_W-1:0] s, bit m);
    in_t it;
    it.sample_in = s;
    it.mute_request = m;
    return it;
  endfunction

  function automatic in_t rand_item(bit m);
    logic signed [SMP_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'sh8000;
      1:       s = 16'sh7FFF;
      2:       s = 16'($urandom_range(0, 6)) - 16'sd3;
      default: s = 16'($urandom);
    endcase
    return make_item(s, m);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    regs_written++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // hold the bus idle before the next transfer
    @(negedge clk);
  endtask

  task automatic load_regs(input int unsigned rl, input int unsigned st, input bit gt);
    write_reg(REG_RAMP_LENGTH, rl);
    write_reg(REG_PHASE_STEP, st);
    write_reg(REG_GATE_ENABLE, 32'(gt));
  endtask

  // Called and returns at a falling edge.
  task automatic send_item(input in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      burst_left = quiet ? 1000 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    board.take_sample(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic put(input int s, input bit m);
    send_item(make_item(SMP_W'(s), m));
  endtask

  // Drop valid, wait for every expected transfer, then let the pipe empty.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Mostly full mute/unmute runs so ramps complete; some cut short, some noise.
  task automatic play_runs(input int n);
    int unsigned r;
    int len, sent, pick;
    bit lvl;
    r = board.active_ramp();
    lvl = $urandom_range(0, 1);
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 9);
      lvl = !lvl;
      if (pick < 7) len = $urandom_range(r + 1, r + 6);
      else if (pick < 9) len = $urandom_range(1, (r > 1) ? r : 1);
      else len = $urandom_range(1, 6);
      repeat (len) begin
        if (sent < n) begin
          send_item(rand_item((pick == 9) ? bit'($urandom_range(0, 1)) : lvl));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int p, n;
    int unsigned rl, st;
    bit gt;
    board = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    quiet = 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Instant switching with no ramp, extremes of the sample.
    load_regs(0, 0, 0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    put(32767, 1);
    put(-32768, 0);
    put(32767, 0);
    put(-1, 0);
    put(1, 0);
    put(0, 1);
    put(-32768, 0);
    wait_drained();

    // Decay entered with count zero, then a full attack and a partial decay.
    load_regs(4, 16384, 1);
    put(12345, 1);
    put(-32768, 1);
    repeat (5) put(32767, 0);
    put(-32768, 1);
    repeat (2) put(32767, 1);
    wait_drained();

    // Ramp cleared in the middle of a decay.
    write_reg(REG_RAMP_LENGTH, 0);
    put(1000, 1);
    put(2000, 0);
    wait_drained();

    // Ramp cleared in the middle of an attack.
    load_regs(8, 8192, 0);
    put(-5000, 1);
    put(5000, 1);
    repeat (3) put(-32768, 0);
    wait_drained();
    write_reg(REG_RAMP_LENGTH, 0);
    put(32767, 0);
    wait_drained();

    for (p = 0; p < 10; p++) begin
      n = 70;
      case (p)
        0: begin rl = 1;    st = 65536;  gt = 1'b1; end
        1: begin rl = 3;    st = 21845;  gt = 1'b0; end
        2: begin rl = 16;   st = 4096;   gt = 1'b1; end
        3: begin rl = 2047; st = 131071; gt = 1'b0; n = 60; end
        4: begin rl = 1024; st = 64;     gt = bit'($urandom_range(0, 1)); n = 1100; end
        7: begin rl = 0;    st = 0;      gt = 1'b1; end
        default: begin
          rl = $urandom_range(1, 40);
          st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : 65536 / rl;
          gt = bit'($urandom_range(0, 1));
        end
      endcase
      quiet = ($urandom_range(0, 2) == 0);
      load_regs(rl, st, gt);
      play_runs(n);
      wait_drained();
    end
    quiet = 1'b0;
    repeat (10) @(negedge clk);

    $display("Covered %0d samples, %0d outputs checked, %0d register writes",
             board.samples_taken, board.outputs_checked, regs_written);
    $display("Ramps 0 to 2047 incl. mid-ramp reloads, gate on and off, random stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("squelch_ramp_gate_test OK");
    end else begin
      $display("squelch_ramp_gate_test NOT OK");
    end
    $finish;
  end

endmodule
